### rtl/core/bis_pkg.sv
package bis_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_DISABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_WAIT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_TIMEOUT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_TIMEOUT  = 2'd3;

    localparam logic [7:0] CLEAR_WAIT_RESET    = 8'd5;
    localparam logic [7:0] WRITE_TIMEOUT_RESET = 8'd3;
    localparam logic [7:0] READ_TIMEOUT_RESET  = 8'd3;
    localparam logic [7:0] TIMER_MAX           = 8'hFF;

    localparam logic [1:0] START_NONE       = 2'd0;
    localparam logic [1:0] START_SETCLK     = 2'd1;
    localparam logic [1:0] START_BOARDCLEAR = 2'd2;

    localparam logic [3:0] GRP_NONE        = 4'd0;
    localparam logic [3:0] GRP_BOARD_RESET = 4'd1;
    localparam logic [3:0] GRP_CLK_CLEAR   = 4'd2;
    localparam logic [3:0] GRP_CLK_WRITE   = 4'd3;
    localparam logic [3:0] GRP_CLK_READ    = 4'd4;
    localparam logic [3:0] GRP_RECEIVERS   = 4'd5;
    localparam logic [3:0] GRP_BLOCKSYNC   = 4'd6;
    localparam logic [3:0] GRP_RAD         = 4'd7;
    localparam logic [3:0] GRP_PPS         = 4'd8;
    localparam logic [3:0] GRP_OUTPUT      = 4'd9;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef enum logic [3:0] {
        STEP_IDLE       = 4'd0,
        STEP_PRECLEAR   = 4'd1,
        STEP_CLKCLEAR   = 4'd2,
        STEP_CLKWRITE   = 4'd3,
        STEP_CLKREAD    = 4'd4,
        STEP_RXOFF      = 4'd5,
        STEP_BOARDCLEAR = 4'd6,
        STEP_BLOCKSYNC  = 4'd7,
        STEP_RAD        = 4'd8,
        STEP_PPS        = 4'd9,
        STEP_RXON       = 4'd10,
        STEP_OUTENABLE  = 4'd11
    } step_t;

    typedef struct packed {
        logic       init_disabled;
        logic [7:0] clear_wait_ticks;
        logic [7:0] write_timeout_ticks;
        logic [7:0] read_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] start_request;
        logic       group_all_idle;
        logic       group_write_pending;
        logic       group_read_error;
        logic       second_is_even;
    } tick_t;

    typedef struct packed {
        step_t      step;
        logic [1:0] current_sequence;
        logic [7:0] tick_timer;
        logic       final_pass;
        logic       wait_odd_second;
        logic       active;
    } state_t;

    typedef struct packed {
        logic [3:0] step_code;
        logic [3:0] issued_group;
        logic [1:0] issued_op;
        logic       receiver_enable;
        logic       cache_clear;
        logic       blocksync_cleared;
        logic       retried;
        logic       finished;
        logic       busy_res;
    } result_t;

endpackage

### rtl/core/bis_if.sv
interface bis_tick_if;
    logic       valid;
    logic       ready;
    logic [1:0] start_request;
    logic       group_all_idle;
    logic       group_write_pending;
    logic       group_read_error;
    logic       second_is_even;

    modport source
    (
        output valid, start_request, group_all_idle, group_write_pending,
               group_read_error, second_is_even,
        input  ready
    );

    modport sink
    (
        input  valid, start_request, group_all_idle, group_write_pending,
               group_read_error, second_is_even,
        output ready
    );
endinterface

interface bis_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] step_code;
    logic [3:0] issued_group;
    logic [1:0] issued_op;
    logic       receiver_enable;
    logic       cache_clear;
    logic       blocksync_cleared;
    logic       retried;
    logic       finished;
    logic       busy_res;

    modport source
    (
        output valid, step_code, issued_group, issued_op, receiver_enable,
               cache_clear, blocksync_cleared, retried, finished, busy_res,
        input  ready
    );

    modport sink
    (
        input  valid, step_code, issued_group, issued_op, receiver_enable,
               cache_clear, blocksync_cleared, retried, finished, busy_res,
        output ready
    );
endinterface

### rtl/core/board_init_sequencer_unit.sv
// Board initialization sequencer, driven by one request per tick.
// The tick channel carries a start request, the status of the register group
// that the current step watches and the parity of the wall-clock second.
// The result channel returns one item per tick with the step reached and the
// command issued on that tick, plus retry, finish and busy flags.
// The configuration write port sets the disable bit and the three tick limits;
// the user must write it only while no tick is in flight, as the block does not enforce this.
// A tick is held in an input register and processed in a single pass of
// combinational logic into the result register, which also updates the state.
// An accepted tick passes from the input register to the result register,
// where its result waits until the receiver takes it.
// One tick is accepted every cycle while the result side keeps up.
// When the receiver stalls, the result register holds its result and the
// input register fills; the tick side then stalls until the result is taken.
// Reset is asynchronous and active low; it returns the sequencer to idle, loads
// the register defaults and empties both registers.
module board_init_sequencer_unit
    import bis_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    bis_tick_if.sink               tick,
    bis_result_if.source           result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    in_valid_reg;
    tick_t   in_data_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    logic    advance;
    logic    take_tick;

    bis_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bis_step_logic u_step
    (
        .cfg       (cfg),
        .tick_in   (in_data_reg),
        .state_cur (state_reg),
        .state_nx  (state_next),
        .res       (res_next)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign take_tick  = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            state_reg.step             <= STEP_IDLE;
            state_reg.current_sequence <= START_NONE;
            state_reg.tick_timer       <= '0;
            state_reg.final_pass       <= 1'b0;
            state_reg.wait_odd_second  <= 1'b0;
            state_reg.active           <= 1'b0;
        end
        else
        begin
            if (take_tick)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_tick)
        begin
            in_data_reg.start_request       <= tick.start_request;
            in_data_reg.group_all_idle      <= tick.group_all_idle;
            in_data_reg.group_write_pending <= tick.group_write_pending;
            in_data_reg.group_read_error    <= tick.group_read_error;
            in_data_reg.second_is_even      <= tick.second_is_even;
        end
        if (advance)
        begin
            out_data_reg <= res_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.step_code         = out_data_reg.step_code;
    assign result.issued_group      = out_data_reg.issued_group;
    assign result.issued_op         = out_data_reg.issued_op;
    assign result.receiver_enable   = out_data_reg.receiver_enable;
    assign result.cache_clear       = out_data_reg.cache_clear;
    assign result.blocksync_cleared = out_data_reg.blocksync_cleared;
    assign result.retried           = out_data_reg.retried;
    assign result.finished          = out_data_reg.finished;
    assign result.busy_res          = out_data_reg.busy_res;

`ifndef SYNTHESIS
    a_busy_matches_step: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.busy_res == (result.step_code != STEP_IDLE)))
        else $error("busy flag disagrees with reported step");

    a_finish_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.finished) |->
            (result.step_code == STEP_IDLE && result.issued_group == GRP_NONE))
        else $error("finished result not idle or still commanding");

    a_rxen_only_receivers: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.receiver_enable) |->
            (result.issued_group == GRP_RECEIVERS && result.issued_op == OP_WRITE))
        else $error("receiver enable issued with wrong command");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a processed tick");
`endif

endmodule

### rtl/core/bis_cfg_regs.sv
module bis_cfg_regs
    import bis_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_disabled       <= 1'b0;
            cfg_reg.clear_wait_ticks    <= CLEAR_WAIT_RESET;
            cfg_reg.write_timeout_ticks <= WRITE_TIMEOUT_RESET;
            cfg_reg.read_timeout_ticks  <= READ_TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INIT_DISABLED: cfg_reg.init_disabled       <= cfg_data[0];
                CFG_CLEAR_WAIT:    cfg_reg.clear_wait_ticks    <= cfg_data;
                CFG_WRITE_TIMEOUT: cfg_reg.write_timeout_ticks <= cfg_data;
                CFG_READ_TIMEOUT:  cfg_reg.read_timeout_ticks  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/bis_step_logic.sv
module bis_step_logic
    import bis_pkg::*;
(
    input  cfg_t    cfg,
    input  tick_t   tick_in,
    input  state_t  state_cur,
    output state_t  state_nx,
    output result_t res
);

    state_t     nx;
    result_t    r;
    logic       do_enter;
    step_t      tgt;
    logic [7:0] tmr_inc;
    logic       wr_expired;
    logic       cw_expired;
    logic       rd_expired;

    assign tmr_inc    = (state_cur.tick_timer == TIMER_MAX) ? state_cur.tick_timer
                                                            : state_cur.tick_timer + 8'd1;
    assign wr_expired = state_cur.tick_timer > cfg.write_timeout_ticks;
    assign cw_expired = state_cur.tick_timer > cfg.clear_wait_ticks;
    assign rd_expired = state_cur.tick_timer > cfg.read_timeout_ticks;

    always_comb
    begin
        nx       = state_cur;
        r        = '0;
        do_enter = 1'b0;
        tgt      = STEP_IDLE;

        unique case (state_cur.step)
            STEP_PRECLEAR:
            begin
                nx.tick_timer = tmr_inc;
                if (cw_expired && tick_in.group_all_idle)
                begin
                    do_enter = 1'b1;
                    tgt      = STEP_CLKCLEAR;
                end
            end
            STEP_CLKCLEAR:
            begin
                if (tick_in.group_all_idle)
                begin
                    do_enter = 1'b1;
                    tgt      = STEP_CLKWRITE;
                end
            end
            STEP_CLKWRITE:
            begin
                if (tick_in.group_all_idle)
                begin
                    do_enter = 1'b1;
                    tgt      = STEP_CLKREAD;
                end
            end
            STEP_CLKREAD:
            begin
                if (tick_in.group_read_error)
                begin
                    nx.tick_timer = tmr_inc;
                    if (rd_expired)
                    begin
                        r.retried = 1'b1;
                        do_enter  = 1'b1;
                        tgt       = STEP_CLKWRITE;
                    end
                    else
                    begin
                        r.issued_group = GRP_CLK_READ;
                        r.issued_op    = OP_READ;
                    end
                end
                else if (tick_in.group_all_idle)
                begin
                    do_enter = 1'b1;
                    tgt      = STEP_RXOFF;
                end
            end
            STEP_RXOFF:
            begin
                nx.tick_timer = tmr_inc;
                if (wr_expired && tick_in.group_write_pending)
                begin
                    r.retried     = 1'b1;
                    nx.final_pass = 1'b0;
                    do_enter      = 1'b1;
                    tgt           = STEP_CLKCLEAR;
                end
                else if (tick_in.group_all_idle)
                begin
                    if (state_cur.final_pass)
                    begin
                        nx.current_sequence = START_NONE;
                        nx.step             = STEP_IDLE;
                        nx.active           = 1'b0;
                        r.finished          = 1'b1;
                    end
                    else
                    begin
                        do_enter = 1'b1;
                        tgt      = STEP_BOARDCLEAR;
                    end
                end
            end
            STEP_BOARDCLEAR:
            begin
                nx.tick_timer = tmr_inc;
                if (cw_expired && tick_in.group_all_idle)
                begin
                    do_enter = 1'b1;
                    tgt      = STEP_BLOCKSYNC;
                end
            end
            STEP_BLOCKSYNC, STEP_RAD, STEP_PPS, STEP_OUTENABLE:
            begin
                nx.tick_timer = tmr_inc;
                if (wr_expired && tick_in.group_write_pending)
                begin
                    r.retried           = 1'b1;
                    r.blocksync_cleared = (state_cur.step == STEP_BLOCKSYNC);
                    do_enter            = 1'b1;
                    tgt                 = STEP_BOARDCLEAR;
                end
                else if (tick_in.group_all_idle)
                begin
                    do_enter = 1'b1;
                    if (state_cur.step == STEP_OUTENABLE)
                    begin
                        nx.final_pass = 1'b1;
                        tgt           = STEP_RXOFF;
                    end
                    else
                    begin
                        tgt = step_t'(4'(state_cur.step + 4'd1));
                    end
                end
            end
            STEP_RXON:
            begin
                if (state_cur.wait_odd_second)
                begin
                    if (!tick_in.second_is_even)
                    begin
                        nx.wait_odd_second = 1'b0;
                        r.issued_group     = GRP_RECEIVERS;
                        r.issued_op        = OP_WRITE;
                        r.receiver_enable  = 1'b1;
                    end
                end
                else
                begin
                    nx.tick_timer = tmr_inc;
                    if (wr_expired && tick_in.group_write_pending)
                    begin
                        r.retried = 1'b1;
                        do_enter  = 1'b1;
                        tgt       = STEP_BOARDCLEAR;
                    end
                    else if (tick_in.group_all_idle)
                    begin
                        do_enter = 1'b1;
                        tgt      = STEP_OUTENABLE;
                    end
                end
            end
            default:
            begin
                nx.step = STEP_IDLE;
                if (!cfg.init_disabled && (tick_in.start_request == START_SETCLK ||
                                           tick_in.start_request == START_BOARDCLEAR))
                begin
                    nx.active           = 1'b1;
                    nx.final_pass       = 1'b0;
                    nx.current_sequence = tick_in.start_request;
                    do_enter            = 1'b1;
                    if (tick_in.start_request == START_SETCLK)
                    begin
                        r.cache_clear = 1'b1;
                        tgt           = STEP_PRECLEAR;
                    end
                    else
                    begin
                        tgt = STEP_BOARDCLEAR;
                    end
                end
            end
        endcase

        if (do_enter)
        begin
            nx.step = tgt;
            unique case (tgt)
                STEP_PRECLEAR, STEP_BOARDCLEAR:
                begin
                    r.issued_group = GRP_BOARD_RESET;
                    r.issued_op    = OP_WRITE;
                    nx.tick_timer  = '0;
                end
                STEP_CLKCLEAR:
                begin
                    r.issued_group = GRP_CLK_CLEAR;
                    r.issued_op    = OP_WRITE;
                end
                STEP_CLKWRITE:
                begin
                    r.issued_group = GRP_CLK_WRITE;
                    r.issued_op    = OP_WRITE;
                end
                STEP_CLKREAD:
                begin
                    r.issued_group = GRP_CLK_READ;
                    r.issued_op    = OP_READ;
                    nx.tick_timer  = '0;
                end
                STEP_RXOFF:
                begin
                    r.issued_group = GRP_RECEIVERS;
                    r.issued_op    = OP_WRITE;
                    nx.tick_timer  = '0;
                end
                STEP_BLOCKSYNC:
                begin
                    r.issued_group = GRP_BLOCKSYNC;
                    r.issued_op    = OP_WRITE;
                    nx.tick_timer  = '0;
                end
                STEP_RAD:
                begin
                    r.issued_group = GRP_RAD;
                    r.issued_op    = OP_WRITE;
                    nx.tick_timer  = '0;
                end
                STEP_PPS:
                begin
                    r.issued_group = GRP_PPS;
                    r.issued_op    = OP_READ;
                    nx.tick_timer  = '0;
                end
                STEP_RXON:
                begin
                    nx.tick_timer = '0;
                    if (tick_in.second_is_even)
                    begin
                        nx.wait_odd_second = 1'b1;
                    end
                    else
                    begin
                        nx.wait_odd_second = 1'b0;
                        r.issued_group     = GRP_RECEIVERS;
                        r.issued_op        = OP_WRITE;
                        r.receiver_enable  = 1'b1;
                    end
                end
                STEP_OUTENABLE:
                begin
                    r.issued_group = GRP_OUTPUT;
                    r.issued_op    = OP_WRITE;
                    nx.tick_timer  = '0;
                end
                default:
                begin
                end
            endcase
        end

        r.step_code = nx.step;
        r.busy_res  = nx.active;
    end

    assign state_nx = nx;
    assign res      = r;

endmodule
